### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NGGP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define NGGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/nggp_pkg.sv
// ----------------------------------------------------------------------------
// nggp_pkg
// Shared types, character codes and constants of the GGA/RMC position parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nggp_pkg;

    localparam int FRAC_DIGITS = 5;
    localparam int INT_DIGITS  = 5;
    localparam logic [16:0] INT_MAX = 17'(10**INT_DIGITS - 1);
    localparam int QUEUE_AW = 2;

    // q = (x * RECIP100) >> 24 is exact for x < 2^17
    localparam logic [17:0] RECIP100 = 18'd167773;
    // minutes scaled by 10^5 to microdegrees is a divide by 6
    localparam logic [24:0] RECIP6   = 25'd22369622;
    localparam logic [19:0] UDEG_PER_DEG = 20'd1000000;
    localparam logic [16:0] MIN_SCALE    = 17'(10**FRAC_DIGITS);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic       KIND_GGA = 1'b0;
    localparam logic       KIND_RMC = 1'b1;

    localparam logic [1:0] LOC_CURRENT = 2'd0;
    localparam logic [1:0] LOC_LAST    = 2'd1;
    localparam logic [1:0] LOC_DEFAULT = 2'd2;

    localparam logic [27:0] DEF_LAT_RESET = 28'd29938971;
    localparam logic [28:0] DEF_LON_RESET = 29'd77564498;

    localparam logic       REG_DEF_LAT = 1'b0;
    localparam logic       REG_DEF_LON = 1'b1;

    // header k: 0 $GPGGA, 1 $GNGGA, 2 $GPRMC, 3 $GNRMC
    function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = k[0] ? 8'h4E : 8'h50;
            3'd3:    c = k[1] ? 8'h52 : 8'h47;
            3'd4:    c = k[1] ? 8'h4D : 8'h47;
            3'd5:    c = k[1] ? 8'h43 : 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // 10^(FRAC_DIGITS - n)
    function automatic logic [16:0] frac_scale(input logic [2:0] n);
        logic [16:0] s;
        s = 17'd1;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (i >= int'(n)) s = 17'(s * 17'd10);
        end
        return s;
    endfunction

    // one finished sentence, handed from front to back; lane 0 lat, lane 1 lon
    typedef struct packed {
        logic              kind;
        logic              qual_ok;
        logic              digits_ok;
        logic              status_a;
        logic [20:0]       time_digits;
        logic [20:0]       date_digits;
        logic [1:0]        present;
        logic [1:0]        flip;
        logic [1:0]        neg;
        logic [1:0][16:0]  ip;
        logic [1:0][16:0]  frac;
        logic [1:0][2:0]   fdc;
    } t_sent;

endpackage

`default_nettype wire

### hw/rtl/nggp_front.sv
// ----------------------------------------------------------------------------
// nggp_front
// Byte parser: header match, field split, number and digit-pair capture.
// Emits one sentence record per finished GGA or RMC line.
// ----------------------------------------------------------------------------
`default_nettype none

module nggp_front import nggp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_rx_byte,
    output t_sent            o_rec,
    output logic             o_push
);

    typedef struct packed {
        logic [3:0]       hpos;
        logic [3:0]       hmatch;
        logic             nonempty;
        logic [3:0]       fnum;
        logic [3:0]       fcnt;
        logic [16:0]      iacc;
        logic [16:0]      facc;
        logic [2:0]       fdc;
        logic             np_dot;
        logic             np_stop;
        logic             np_neg;
        logic [20:0]      ptime;
        logic [20:0]      pdate;
        logic             pair_open;
        logic             q_digits;
        logic             q_stop;
        logic             q_neg;
        logic             q_nz;
        logic             status_a;
        logic             digits_ok;
        logic [1:0]       present;
        logic [1:0]       flip;
        logic [1:0]       neg;
        logic [1:0][16:0] ip;
        logic [1:0][16:0] frac;
        logic [1:0][2:0]  fdc_l;
    } t_fstate;

    typedef struct packed {
        logic [20:0] pk;
        logic        open;
    } t_pair;

    t_fstate r_st, n_st;

    function automatic t_pair pair_step(input logic [20:0] pk, input logic [3:0] pos,
                                        input logic [7:0] ch, input logic open_in);
        t_pair      res;
        logic [6:0] val;
        logic [1:0] slot;
        logic [7:0] dd;
        logic       isd;
        res.pk   = pk;
        res.open = open_in;
        isd      = (ch >= CH_0) && (ch <= CH_9);
        dd       = ch - CH_0;
        if (pos < 4'd6) begin
            slot = pos[2:1];
            val  = pk[7*slot +: 7];
            if (!pos[0]) begin
                if (isd) begin
                    val      = {3'b000, dd[3:0]};
                    res.open = 1'b1;
                end else begin
                    val      = 7'd0;
                    res.open = 1'b0;
                end
            end else if (open_in && isd) begin
                val = 7'(val * 7'd10 + {3'b000, dd[3:0]});
            end
            res.pk[7*slot +: 7] = val;
        end
        return res;
    endfunction

    always_comb begin
        logic        v_gga;
        logic        v_rmc;
        logic [3:0]  v_f;
        logic [3:0]  v_c;
        logic [7:0]  v_dd;
        logic        v_isd;
        logic [20:0] v_acc;
        logic        v_go;
        logic        v_end;
        logic        v_lane;
        t_pair       v_pair;

        n_st   = r_st;
        o_push = 1'b0;
        o_rec  = '0;
        v_gga  = 1'b0;
        v_rmc  = 1'b0;
        v_f    = r_st.fnum;
        v_c    = r_st.fcnt;
        v_dd   = i_rx_byte - CH_0;
        v_isd  = (i_rx_byte >= CH_0) && (i_rx_byte <= CH_9);
        v_acc  = '0;
        v_go   = 1'b0;
        v_lane = 1'b0;
        v_pair = '0;
        v_end  = i_accept && ((i_rx_byte == CH_COMMA) ||
                 ((i_rx_byte == CH_LF) && r_st.nonempty));

        if (i_accept && (i_rx_byte != CH_CR) && (i_rx_byte != CH_LF)) begin
            if (n_st.hpos == 4'd0) n_st.hmatch = 4'hF;
            if (n_st.hpos < 4'd6) begin
                for (int k = 0; k < 4; k++) begin
                    if (hdr_char(2'(k), n_st.hpos[2:0]) != i_rx_byte) n_st.hmatch[k] = 1'b0;
                end
                n_st.hpos = n_st.hpos + 4'd1;
            end
            n_st.nonempty = 1'b1;
        end

        v_gga = (n_st.hpos >= 4'd6) && (|n_st.hmatch[1:0]);
        v_rmc = (n_st.hpos >= 4'd6) && (|n_st.hmatch[3:2]);

        // body character
        if (i_accept && (i_rx_byte != CH_CR) && (i_rx_byte != CH_LF) &&
            (i_rx_byte != CH_COMMA)) begin
            if (v_gga) begin
                if (v_f == 4'd1) begin
                    v_pair         = pair_step(n_st.ptime, v_c, i_rx_byte, n_st.pair_open);
                    n_st.ptime     = v_pair.pk;
                    n_st.pair_open = v_pair.open;
                end else if ((v_f == 4'd2) || (v_f == 4'd4)) begin
                    if (!n_st.np_stop) begin
                        if ((v_c == 4'd0) &&
                            ((i_rx_byte == CH_PLUS) || (i_rx_byte == CH_MINUS))) begin
                            if (i_rx_byte == CH_MINUS) n_st.np_neg = 1'b1;
                        end else if (v_isd) begin
                            if (!n_st.np_dot) begin
                                v_acc = 21'(n_st.iacc) * 21'd10 + 21'(v_dd[3:0]);
                                n_st.iacc = (v_acc > 21'(INT_MAX)) ? INT_MAX : v_acc[16:0];
                            end else if (n_st.fdc < 3'(FRAC_DIGITS)) begin
                                v_acc     = 21'(n_st.facc) * 21'd10 + 21'(v_dd[3:0]);
                                n_st.facc = v_acc[16:0];
                                n_st.fdc  = n_st.fdc + 3'd1;
                            end
                        end else if ((i_rx_byte == CH_DOT) && !n_st.np_dot) begin
                            n_st.np_dot = 1'b1;
                        end else begin
                            n_st.np_stop = 1'b1;
                        end
                    end
                end else if ((v_f == 4'd3) && (v_c == 4'd0) && (i_rx_byte == CH_S)) begin
                    n_st.flip[0] = 1'b1;
                end else if ((v_f == 4'd5) && (v_c == 4'd0) && (i_rx_byte == CH_W)) begin
                    n_st.flip[1] = 1'b1;
                end else if (v_f == 4'd6) begin
                    if (!n_st.q_stop) begin
                        v_go = 1'b1;
                        if (!n_st.q_digits) begin
                            if ((i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB) ||
                                (i_rx_byte == CH_VT) || (i_rx_byte == CH_FF)) begin
                                v_go = 1'b0;
                            end else begin
                                n_st.q_digits = 1'b1;
                                if ((i_rx_byte == CH_PLUS) || (i_rx_byte == CH_MINUS)) begin
                                    v_go = 1'b0;
                                    if (i_rx_byte == CH_MINUS) n_st.q_neg = 1'b1;
                                end
                            end
                        end
                        if (v_go) begin
                            if (v_isd) begin
                                if (i_rx_byte != CH_0) n_st.q_nz = 1'b1;
                            end else begin
                                n_st.q_stop = 1'b1;
                            end
                        end
                    end
                end
            end else if (v_rmc) begin
                if ((v_f == 4'd2) && (v_c == 4'd0) && (i_rx_byte == CH_A)) begin
                    n_st.status_a = 1'b1;
                end else if (v_f == 4'd9) begin
                    v_pair         = pair_step(n_st.pdate, v_c, i_rx_byte, n_st.pair_open);
                    n_st.pdate     = v_pair.pk;
                    n_st.pair_open = v_pair.open;
                end
            end
            if (n_st.fcnt != 4'hF) n_st.fcnt = n_st.fcnt + 4'd1;
        end

        // field end: comma or newline of a nonempty line
        if (v_end) begin
            if (v_gga) begin
                if ((v_f == 4'd1) && (v_c >= 4'd6)) n_st.digits_ok = 1'b1;
                if ((v_f == 4'd2) || (v_f == 4'd4)) begin
                    v_lane = (v_f == 4'd4);
                    if (v_c != 4'd0) n_st.present[v_lane] = 1'b1;
                    n_st.ip[v_lane]    = n_st.iacc;
                    n_st.frac[v_lane]  = n_st.facc;
                    n_st.fdc_l[v_lane] = n_st.fdc;
                    n_st.neg[v_lane]   = n_st.np_neg;
                end
                if ((v_f == 4'd3) && (v_c != 4'd1)) n_st.flip[0] = 1'b0;
                if ((v_f == 4'd5) && (v_c != 4'd1)) n_st.flip[1] = 1'b0;
            end else if (v_rmc) begin
                if ((v_f == 4'd2) && (v_c != 4'd1)) n_st.status_a = 1'b0;
                if ((v_f == 4'd9) && (v_c >= 4'd6)) n_st.digits_ok = 1'b1;
            end
            n_st.fcnt      = 4'd0;
            n_st.iacc      = '0;
            n_st.facc      = '0;
            n_st.fdc       = '0;
            n_st.np_dot    = 1'b0;
            n_st.np_stop   = 1'b0;
            n_st.np_neg    = 1'b0;
            n_st.pair_open = 1'b0;
        end

        if (i_accept && (i_rx_byte == CH_COMMA) && (n_st.fnum != 4'hF)) begin
            n_st.fnum = n_st.fnum + 4'd1;
        end

        if (i_accept && (i_rx_byte == CH_LF) && r_st.nonempty) begin
            o_push            = v_gga || v_rmc;
            o_rec.kind        = v_gga ? KIND_GGA : KIND_RMC;
            o_rec.qual_ok     = n_st.q_nz && !n_st.q_neg;
            o_rec.digits_ok   = n_st.digits_ok;
            o_rec.status_a    = n_st.status_a;
            o_rec.time_digits = n_st.ptime;
            o_rec.date_digits = n_st.pdate;
            o_rec.present     = n_st.present;
            o_rec.flip        = n_st.flip;
            o_rec.neg         = n_st.neg;
            o_rec.ip          = n_st.ip;
            o_rec.frac        = n_st.frac;
            o_rec.fdc         = n_st.fdc_l;
            n_st              = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nggp_queue.sv
// ----------------------------------------------------------------------------
// nggp_queue
// Small FIFO of sentence records between the parser and the update engine.
// ----------------------------------------------------------------------------
`default_nettype none

module nggp_queue import nggp_pkg::*; #(
    parameter int AW = QUEUE_AW
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_sent      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_sent      o_data,
    output logic       o_empty
);

    localparam int DEPTH = 2**AW;

    t_sent         r_mem [DEPTH];
    logic [AW:0]   r_wr;
    logic [AW:0]   r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW-1:0] == r_rd[AW-1:0]) && (r_wr[AW] != r_rd[AW]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr[AW-1:0]] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nggp_back.sv
// ----------------------------------------------------------------------------
// nggp_back
// Update engine: converts DDMM.MMMMM to microdegrees over four steps, updates
// fix, time and date state and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nggp_back import nggp_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_sent                   i_rec,
    input  wire logic               i_rec_valid,
    output logic                    o_rec_pop,
    input  wire logic signed [27:0] i_def_lat,
    input  wire logic signed [28:0] i_def_lon,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic                    o_sentence_kind,
    output logic                    o_fix_valid,
    output logic                    o_time_valid,
    output logic [6:0]              o_hour,
    output logic [6:0]              o_minute,
    output logic [6:0]              o_second,
    output logic [6:0]              o_day,
    output logic [6:0]              o_month,
    output logic [11:0]             o_year,
    output logic [1:0]              o_location_status,
    output logic signed [30:0]      o_latitude_udeg,
    output logic signed [30:0]      o_longitude_udeg
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV100, S_MINS, S_DIV6, S_SUM, S_COMMIT
    } t_state;

    t_state                  r_state;
    t_sent                   r_rec;
    logic [1:0][9:0]         r_q;
    logic [1:0][16:0]        r_fs;
    logic [1:0][23:0]        r_mins;
    logic [1:0][20:0]        r_m6;
    logic [1:0][30:0]        r_pos;
    logic [1:0][30:0]        r_cur;
    logic                    r_fix;
    logic                    r_last;
    logic                    r_tv;
    logic [20:0]             r_time;
    logic [25:0]             r_date;
    logic                    r_out_valid;

    logic                    n_fix;
    logic                    n_last;
    logic                    n_tv;
    logic [20:0]             n_time;
    logic [25:0]             n_date;
    logic [1:0][30:0]        n_cur;
    logic [1:0]              n_loc;
    logic [1:0][30:0]        n_loc_pos;
    logic [6:0]              v_yy;
    logic                    w_slot_free;
    logic                    w_commit;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_commit    = (r_state == S_COMMIT) && w_slot_free;
    assign o_rec_pop   = (r_state == S_IDLE) && i_rec_valid;
    assign o_empty     = !r_out_valid;

    // state update taken at commit
    always_comb begin
        n_fix  = r_fix;
        n_last = r_last;
        n_tv   = r_tv;
        n_time = r_time;
        n_date = r_date;
        n_cur  = r_cur;
        v_yy   = r_rec.date_digits[20:14];
        if (r_rec.kind == KIND_GGA) begin
            if (r_rec.qual_ok) begin
                if (r_rec.digits_ok) begin
                    n_time = r_rec.time_digits;
                    n_tv   = 1'b1;
                end
                if (&r_rec.present) begin
                    n_cur  = r_pos;
                    n_fix  = 1'b1;
                    n_last = 1'b1;
                end
            end else begin
                n_fix = 1'b0;
            end
        end else if (r_rec.status_a && r_rec.digits_ok) begin
            n_date = {(v_yy < 7'd80) ? 12'd2000 + 12'(v_yy) : 12'd1900 + 12'(v_yy),
                      r_rec.date_digits[13:0]};
        end
        if (n_fix) begin
            n_loc     = LOC_CURRENT;
            n_loc_pos = n_cur;
        end else if (n_last) begin
            n_loc     = LOC_LAST;
            n_loc_pos = n_cur;
        end else begin
            n_loc        = LOC_DEFAULT;
            n_loc_pos[0] = {{3{i_def_lat[27]}}, i_def_lat};
            n_loc_pos[1] = {{2{i_def_lon[28]}}, i_def_lon};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [34:0] v_p100;
        logic [16:0] v_rem;
        logic [48:0] v_p6;
        logic [30:0] v_mag;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fix       <= 1'b0;
            r_last      <= 1'b0;
            r_tv        <= 1'b0;
            r_time      <= '0;
            r_date      <= '0;
            r_cur       <= '0;
        end else begin
            // a commit in the same cycle refills the slot
            if (i_pop && r_out_valid && !w_commit) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_rec_valid) begin
                        r_rec   <= i_rec;
                        r_state <= S_DIV100;
                    end
                end
                S_DIV100: begin
                    for (int i = 0; i < 2; i++) begin
                        v_p100  = 35'(r_rec.ip[i]) * 35'(RECIP100);
                        r_q[i]  <= v_p100[33:24];
                        r_fs[i] <= 17'(r_rec.frac[i] * frac_scale(r_rec.fdc[i]));
                    end
                    r_state <= S_MINS;
                end
                S_MINS: begin
                    for (int i = 0; i < 2; i++) begin
                        v_rem     = r_rec.ip[i] - 17'(r_q[i]) * 17'd100;
                        r_mins[i] <= 24'(v_rem[6:0]) * 24'(MIN_SCALE) + 24'(r_fs[i]);
                    end
                    r_state <= S_DIV6;
                end
                S_DIV6: begin
                    for (int i = 0; i < 2; i++) begin
                        v_p6    = 49'(r_mins[i]) * 49'(RECIP6);
                        r_m6[i] <= v_p6[47:27];
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    for (int i = 0; i < 2; i++) begin
                        v_mag = 31'(r_q[i]) * 31'(UDEG_PER_DEG) + 31'(r_m6[i]);
                        r_pos[i] <= (r_rec.neg[i] ^ r_rec.flip[i]) ? -v_mag : v_mag;
                    end
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_slot_free) begin
                        r_fix             <= n_fix;
                        r_last            <= n_last;
                        r_tv              <= n_tv;
                        r_time            <= n_time;
                        r_date            <= n_date;
                        r_cur             <= n_cur;
                        r_out_valid       <= 1'b1;
                        o_sentence_kind   <= r_rec.kind;
                        o_fix_valid       <= n_fix;
                        o_time_valid      <= n_tv;
                        o_hour            <= n_time[6:0];
                        o_minute          <= n_time[13:7];
                        o_second          <= n_time[20:14];
                        o_day             <= n_date[6:0];
                        o_month           <= n_date[13:7];
                        o_year            <= n_date[25:14];
                        o_location_status <= n_loc;
                        o_latitude_udeg   <= n_loc_pos[0];
                        o_longitude_udeg  <= n_loc_pos[1];
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nmea_gga_rmc_position_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_gga_rmc_position_parser_top
// NMEA GGA/RMC position parser: byte stream in, one fix/time/date beat per
// finished GGA or RMC sentence out.
//
//   port group   dir   handshake                     payload
//   rx bytes     in    push / full                   i_rx_byte
//   results      out   empty / pop                   o_sentence_kind .. o_longitude_udeg
//   config       in    psel penable pwrite / pready  paddr pwdata prdata
//
// One byte per cycle at the parser while full is low. Each GGA/RMC sentence
// then passes through the update engine (idle, four conversion steps,
// commit); the record queue (2**QUEUE_AW deep) absorbs that, so full rises
// only when results back up. Reset is synchronous, active low; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_rmc_position_parser_top import nggp_pkg::*; #(
    parameter int QUEUE_DEPTH_LOG2 = QUEUE_AW
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_rx_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic              o_sentence_kind,
    output logic              o_fix_valid,
    output logic              o_time_valid,
    output logic [6:0]        o_hour,
    output logic [6:0]        o_minute,
    output logic [6:0]        o_second,
    output logic [6:0]        o_day,
    output logic [6:0]        o_month,
    output logic [11:0]       o_year,
    output logic [1:0]        o_location_status,
    output logic signed [30:0] o_latitude_udeg,
    output logic signed [30:0] o_longitude_udeg,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic signed [27:0] r_def_lat;
    logic signed [28:0] r_def_lon;

    t_sent  w_rec_in;
    t_sent  w_rec_out;
    logic   w_push;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_q_pop;

    assign pready = 1'b1;
    assign full   = w_q_full;
    assign prdata = (paddr[2] == REG_DEF_LON) ? {3'b000, r_def_lon} : {4'b0000, r_def_lat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_lat <= DEF_LAT_RESET;
            r_def_lon <= DEF_LON_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_DEF_LAT) r_def_lat <= pwdata[27:0];
            else                         r_def_lon <= pwdata[28:0];
        end
    end

    nggp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (push && !w_q_full),
        .i_rx_byte (i_rx_byte),
        .o_rec     (w_rec_in),
        .o_push    (w_push)
    );

    nggp_queue #(.AW(QUEUE_DEPTH_LOG2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rec_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_rec_out),
        .o_empty (w_q_empty)
    );

    nggp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rec             (w_rec_out),
        .i_rec_valid       (!w_q_empty),
        .o_rec_pop         (w_q_pop),
        .i_def_lat         (r_def_lat),
        .i_def_lon         (r_def_lon),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_sentence_kind   (o_sentence_kind),
        .o_fix_valid       (o_fix_valid),
        .o_time_valid      (o_time_valid),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second),
        .o_day             (o_day),
        .o_month           (o_month),
        .o_year            (o_year),
        .o_location_status (o_location_status),
        .o_latitude_udeg   (o_latitude_udeg),
        .o_longitude_udeg  (o_longitude_udeg)
    );

endmodule

`default_nettype wire

### hw/rtl/nggp_checker.sv
// ----------------------------------------------------------------------------
// nggp_checker
// Port-level checks on the result side, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nggp_checker import nggp_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic              o_fix_valid,
    input wire logic [1:0]        o_location_status,
    input wire logic signed [30:0] o_latitude_udeg,
    input wire logic signed [30:0] o_longitude_udeg
);

    // a live fix always reports the current position, and only then
    `NGGP_ASSERT_IMPL(a_fix_current, !empty && o_fix_valid, o_location_status == LOC_CURRENT)
    `NGGP_ASSERT_IMPL(a_current_fix, !empty && o_location_status == LOC_CURRENT, o_fix_valid)
    // a waiting beat holds until taken
    `NGGP_ASSERT_NEXT(a_hold, !empty && !pop,
        !empty && $stable(o_latitude_udeg) && $stable(o_longitude_udeg))

endmodule

bind nmea_gga_rmc_position_parser_top nggp_checker u_checker (.*);

`default_nettype wire
